FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on a rising edge with an
// active-low reset that disables the check
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define TRT_ASSERT_IMP(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TRT_ASSERT_NXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/trt_pkg.sv
// ----------------------------------------------------------------------------
// trt_pkg
// types, constants and beat layouts of the transaction reservation table
// ----------------------------------------------------------------------------
package trt_pkg;

    // default sizing
    localparam int TABLE_COUNT_DEF = 4;
    localparam int KEY_BITS_DEF    = 10;
    localparam int TID_BITS_DEF    = 32;

    // fixed field widths on the stream ports
    localparam int TABLE_IDX_W = 2;
    localparam int KEY_IDX_W   = 10;
    localparam int TXN_ID_W    = 32;

    // input beat layout
    localparam int S_TDATA_W   = 48;
    localparam int S_TUSER_W   = 2;
    localparam int S_TABLE_LSB = 0;
    localparam int S_KEY_LSB   = S_TABLE_LSB + TABLE_IDX_W;
    localparam int S_TXN_LSB   = S_KEY_LSB + KEY_IDX_W;
    localparam int S_USER_REQ  = 0;
    localparam int S_USER_WR   = 1;

    // output beat layout
    localparam int FLAG_W      = 3;
    localparam int M_TDATA_W   = 8;
    localparam int M_TUSER_W   = 1;

    // bit positions in the dependency flag vector
    localparam int FLAG_WAW = 0;
    localparam int FLAG_WAR = 1;
    localparam int FLAG_RAW = 2;

    // request kinds
    localparam logic REQ_RESERVE = 1'b0;
    localparam logic REQ_ANALYZE = 1'b1;

    typedef struct packed {
        logic                   req_type;
        logic                   is_write;
        logic [TABLE_IDX_W-1:0] table_index;
        logic [KEY_IDX_W-1:0]   key_index;
        logic [TXN_ID_W-1:0]    txn_id;
        logic                   last_access;
    } req_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic clear_step;
        logic capture;
        logic execute;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic stall;
    } status_t;

endpackage

FILE: design/trt_ram.sv
// ----------------------------------------------------------------------------
// trt_ram
// simple dual-port ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module trt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/trt_ctrl.sv
// ----------------------------------------------------------------------------
// trt_ctrl
// sequencer: clearing pass after reset, then capture and execute per access
// ----------------------------------------------------------------------------
module trt_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  trt_pkg::status_t status,
    output trt_pkg::cmd_t    cmd
);

    trt_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= trt_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            trt_pkg::ST_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (status.clear_last) begin
                    state_next = trt_pkg::ST_IDLE;
                end
            end
            trt_pkg::ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
                if (s_tvalid) begin
                    state_next = trt_pkg::ST_EXEC;
                end
            end
            trt_pkg::ST_EXEC: begin
                // hold while the result register is still occupied
                if (!status.stall) begin
                    cmd.execute = 1'b1;
                    state_next  = trt_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = trt_pkg::ST_CLEAR;
            end
        endcase
    end

endmodule

FILE: design/trt_dpath.sv
// ----------------------------------------------------------------------------
// trt_dpath
// stamp stores, request latch, stamp compare and reserve update, dependency
// flags and result register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module trt_dpath #(
    parameter int TABLE_COUNT = trt_pkg::TABLE_COUNT_DEF,
    parameter int KEY_BITS    = trt_pkg::KEY_BITS_DEF,
    parameter int TID_BITS    = trt_pkg::TID_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  trt_pkg::cmd_t               cmd,
    output trt_pkg::status_t            status,
    input  trt_pkg::req_t               req,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        out_kind,
    output logic [trt_pkg::FLAG_W-1:0]  out_flags
);

    localparam int DEPTH  = TABLE_COUNT << KEY_BITS;
    localparam int ADDR_W = $clog2(DEPTH);

    // request latch
    logic                       req_type_reg;
    logic                       req_write_reg;
    logic                       req_valid_reg;
    logic                       req_last_reg;
    logic [ADDR_W-1:0]          req_slot_reg;
    logic [TID_BITS-1:0]        tid_reg;

    logic [ADDR_W-1:0]          clr_cnt_reg, clr_cnt_next;
    logic [trt_pkg::FLAG_W-1:0] flags_reg, flags_next;
    logic                       out_valid_reg, out_valid_next;
    logic                       out_kind_reg;
    logic [trt_pkg::FLAG_W-1:0] out_flags_reg;

    logic [ADDR_W-1:0]          in_slot;
    logic                       in_valid;
    logic [TID_BITS-1:0]        in_tid;
    logic [TID_BITS-1:0]        rs_raw, ws_raw, rs, ws;
    logic [TID_BITS-1:0]        cur_stamp;
    logic                       rsv_we;
    logic                       rd_we, wr_we;
    logic [ADDR_W-1:0]          waddr;
    logic [TID_BITS-1:0]        wdata;
    logic [trt_pkg::FLAG_W-1:0] hit_flags, acc_flags;

    // slot is table * key slots + key, invalid tables read as unreserved
    assign in_slot  = (ADDR_W'(req.table_index) << KEY_BITS) | ADDR_W'(KEY_BITS'(req.key_index));
    assign in_valid = 32'(req.table_index) < TABLE_COUNT;
    assign in_tid   = TID_BITS'(req.txn_id);

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_type_reg  <= req.req_type;
            req_write_reg <= req.is_write;
            req_valid_reg <= in_valid;
            req_last_reg  <= req.last_access;
            req_slot_reg  <= in_slot;
            tid_reg       <= in_tid;
        end
    end

    assign rs = req_valid_reg ? rs_raw : '0;
    assign ws = req_valid_reg ? ws_raw : '0;

    // reserve keeps the smallest nonzero id
    assign cur_stamp = req_write_reg ? ws : rs;
    assign rsv_we    = cmd.execute && (req_type_reg == trt_pkg::REQ_RESERVE) && req_valid_reg
                       && (tid_reg != '0) && ((cur_stamp == '0) || (cur_stamp > tid_reg));

    assign rd_we = cmd.clear_step || (rsv_we && !req_write_reg);
    assign wr_we = cmd.clear_step || (rsv_we && req_write_reg);
    assign waddr = cmd.clear_step ? clr_cnt_reg : req_slot_reg;
    assign wdata = cmd.clear_step ? '0 : tid_reg;

    trt_ram #(
        .WIDTH(TID_BITS),
        .DEPTH(DEPTH)
    ) u_read_stamp (
        .aclk (aclk),
        .we   (rd_we),
        .waddr(waddr),
        .wdata(wdata),
        .re   (cmd.capture),
        .raddr(in_slot),
        .rdata(rs_raw)
    );

    trt_ram #(
        .WIDTH(TID_BITS),
        .DEPTH(DEPTH)
    ) u_write_stamp (
        .aclk (aclk),
        .we   (wr_we),
        .waddr(waddr),
        .wdata(wdata),
        .re   (cmd.capture),
        .raddr(in_slot),
        .rdata(ws_raw)
    );

    always_comb begin
        hit_flags = '0;
        if (req_type_reg == trt_pkg::REQ_ANALYZE) begin
            if (req_write_reg) begin
                hit_flags[trt_pkg::FLAG_WAW] = (ws != '0) && (ws < tid_reg);
                hit_flags[trt_pkg::FLAG_WAR] = (rs != '0) && (rs < tid_reg);
            end else begin
                hit_flags[trt_pkg::FLAG_RAW] = (ws != '0) && (ws < tid_reg);
            end
        end
    end

    assign acc_flags = flags_reg | hit_flags;

    always_comb begin
        clr_cnt_next   = clr_cnt_reg;
        flags_next     = flags_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (cmd.clear_step) begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
        end
        if (cmd.execute) begin
            flags_next = req_last_reg ? '0 : acc_flags;
            if (req_last_reg) begin
                out_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg   <= '0;
            flags_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            clr_cnt_reg   <= clr_cnt_next;
            flags_reg     <= flags_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.execute && req_last_reg) begin
            out_kind_reg  <= req_type_reg;
            out_flags_reg <= (req_type_reg == trt_pkg::REQ_ANALYZE) ? acc_flags : '0;
        end
    end

    assign status.clear_last = (clr_cnt_reg == ADDR_W'(DEPTH - 1));
    assign status.stall      = req_last_reg && out_valid_reg && !out_ready;

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_flags = out_flags_reg;

    `TRT_ASSERT_IMP(a_clear_excl, aclk, aresetn, cmd.clear_step,
        !cmd.capture && !cmd.execute, "access handled during clearing pass")
    `TRT_ASSERT_IMP(a_out_free, aclk, aresetn, cmd.execute && req_last_reg,
        !out_valid_reg || out_ready, "result overwrites an untaken result")
    `TRT_ASSERT_NXT(a_out_load, aclk, aresetn, cmd.execute && req_last_reg,
        out_valid_reg, "last access gave no result")
    `TRT_ASSERT_IMP(a_rsv_id, aclk, aresetn, rsv_we,
        (tid_reg != '0) && req_valid_reg, "reserve wrote a zero id or a bad table")

endmodule

FILE: design/transaction_reservation_table_top.sv
// result: m_tvalid rises once the last access is executed and the result register
// is loaded; a new access waits until the last one is done, as the registered stamp
// read is followed by the read-modify-write of that entry; a full result register
// not taken holds a last access. reset: a clearing pass zeroes both stamp stores,
// TABLE_COUNT << KEY_BITS entries (4096 by default), with s_tready low until it ends
// ----------------------------------------------------------------------------
// transaction_reservation_table_top
// read and write stamp reservation with dependency analysis over a stream port
// ----------------------------------------------------------------------------
module transaction_reservation_table_top #(
    parameter int TABLE_COUNT = trt_pkg::TABLE_COUNT_DEF,
    parameter int KEY_BITS    = trt_pkg::KEY_BITS_DEF,
    parameter int TID_BITS    = trt_pkg::TID_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // table_index[1:0], key_index[11:2], txn_id[43:12], zero pad
    input  logic [trt_pkg::S_TDATA_W-1:0] s_tdata,
    // req_type[0], is_write[1]
    input  logic [trt_pkg::S_TUSER_W-1:0] s_tuser,
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // waw_found[0], war_found[1], raw_found[2], zero pad
    output logic [trt_pkg::M_TDATA_W-1:0] m_tdata,
    // done_kind[0]
    output logic [trt_pkg::M_TUSER_W-1:0] m_tuser
);

    trt_pkg::cmd_t              cmd;
    trt_pkg::status_t           status;
    trt_pkg::req_t              req;
    logic                       out_kind;
    logic [trt_pkg::FLAG_W-1:0] out_flags;

    always_comb begin
        req.req_type    = s_tuser[trt_pkg::S_USER_REQ];
        req.is_write    = s_tuser[trt_pkg::S_USER_WR];
        req.table_index = s_tdata[trt_pkg::S_TABLE_LSB +: trt_pkg::TABLE_IDX_W];
        req.key_index   = s_tdata[trt_pkg::S_KEY_LSB +: trt_pkg::KEY_IDX_W];
        req.txn_id      = s_tdata[trt_pkg::S_TXN_LSB +: trt_pkg::TXN_ID_W];
        req.last_access = s_tlast;
    end

    trt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .status  (status),
        .cmd     (cmd)
    );

    trt_dpath #(
        .TABLE_COUNT(TABLE_COUNT),
        .KEY_BITS   (KEY_BITS),
        .TID_BITS   (TID_BITS)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .req      (req),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_kind (out_kind),
        .out_flags(out_flags)
    );

    assign m_tdata = trt_pkg::M_TDATA_W'(out_flags);
    assign m_tuser = trt_pkg::M_TUSER_W'(out_kind);

endmodule

FILE: test/tb_transaction_reservation_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_transaction_reservation_table_top
// stream-level test of the reservation table: directed accesses, a stalled
// receiver, and random reserve/analyze batches over a shared key pool, each
// checked against a local model of the stamp stores and dependency flags
// ----------------------------------------------------------------------------
module tb_transaction_reservation_table_top;
    import trt_pkg::*;

    localparam int SLOTS = TABLE_COUNT_DEF << KEY_BITS_DEF;

    typedef struct packed {
        logic       done_kind;
        logic [2:0] flags;
    } dep_report_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic [S_TUSER_W-1:0]   s_tuser;
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [M_TUSER_W-1:0]   m_tuser;

    // local copy of the stamp stores and the running flags
    logic [TXN_ID_W-1:0] read_marks  [0:SLOTS-1];
    logic [TXN_ID_W-1:0] write_marks [0:SLOTS-1];
    logic [FLAG_W-1:0]   running_deps;
    dep_report_t         pending_reports [$];

    int  error_count;
    int  items_sent;
    bit  tx_idle_en;
    bit  rx_idle_en;
    int  holdoff_request;

    transaction_reservation_table_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    task automatic report_mismatch(input string what, input longint want_v, input longint got_v);
        $display("mismatch at %0t: %s expected %0d got %0d", $time, what, want_v, got_v);
        error_count++;
    endtask

    // update the stamp model with one accepted access and queue its report
    function automatic void resolve_access(input req_t a);
        int unsigned   slot;
        logic [31:0]   rs;
        logic [31:0]   ws;
        dep_report_t   rep;
        slot = {a.table_index, a.key_index};
        rs   = read_marks[slot];
        ws   = write_marks[slot];
        if (a.req_type == REQ_RESERVE) begin
            if (a.txn_id != 0) begin
                if (a.is_write) begin
                    if (ws == 0 || ws > a.txn_id) write_marks[slot] = a.txn_id;
                end else begin
                    if (rs == 0 || rs > a.txn_id) read_marks[slot] = a.txn_id;
                end
            end
        end else begin
            if (a.is_write) begin
                if (ws != 0 && ws < a.txn_id) running_deps[FLAG_WAW] = 1'b1;
                if (rs != 0 && rs < a.txn_id) running_deps[FLAG_WAR] = 1'b1;
            end else begin
                if (ws != 0 && ws < a.txn_id) running_deps[FLAG_RAW] = 1'b1;
            end
        end
        if (a.last_access) begin
            rep.done_kind = a.req_type;
            rep.flags     = (a.req_type == REQ_ANALYZE) ? running_deps : '0;
            pending_reports.push_back(rep);
            running_deps = '0;
        end
    endfunction

    // called at a falling edge; returns at the falling edge after the beat is taken
    task automatic send_access(input req_t a);
        logic [S_TDATA_W-1:0] data;
        if (tx_idle_en) begin
            while ($urandom_range(99) < 27) begin
                s_tvalid = 1'b0;
                @(negedge aclk);
            end
        end
        data = '0;
        data[S_TABLE_LSB +: TABLE_IDX_W] = a.table_index;
        data[S_KEY_LSB +: KEY_IDX_W]     = a.key_index;
        data[S_TXN_LSB +: TXN_ID_W]      = a.txn_id;
        s_tdata              = data;
        s_tuser[S_USER_REQ]  = a.req_type;
        s_tuser[S_USER_WR]   = a.is_write;
        s_tlast              = a.last_access;
        s_tvalid             = 1'b1;
        do @(posedge aclk); while (!s_tready);
        resolve_access(a);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic wait_reports_drained();
        s_tvalid = 1'b0;
        while (pending_reports.size() != 0) @(negedge aclk);
    endtask

    function automatic req_t make_access(input logic kind, input logic wr, input int tbl,
                                         input int key, input logic [31:0] tid,
                                         input logic last);
        req_t a;
        a.req_type    = kind;
        a.is_write    = wr;
        a.table_index = tbl[TABLE_IDX_W-1:0];
        a.key_index   = key[KEY_IDX_W-1:0];
        a.txn_id      = tid;
        a.last_access = last;
        return a;
    endfunction

    function automatic req_t noise_access();
        return make_access($urandom_range(1), $urandom_range(1), $urandom_range(3),
                           $urandom_range(1023), $urandom, $urandom_range(1));
    endfunction

    task automatic test_directed();
        req_t seq [$];
        seq.push_back(make_access(REQ_RESERVE, 1, 0, 0, 100, 0));
        seq.push_back(make_access(REQ_RESERVE, 0, 0, 0, 50, 1));
        // larger id does not replace the stamp
        seq.push_back(make_access(REQ_RESERVE, 1, 0, 0, 200, 1));
        // zero id reserves nothing
        seq.push_back(make_access(REQ_RESERVE, 1, 0, 0, 0, 1));
        seq.push_back(make_access(REQ_ANALYZE, 1, 0, 0, 150, 1));
        seq.push_back(make_access(REQ_ANALYZE, 0, 0, 0, 150, 1));
        // equal stamp is not earlier
        seq.push_back(make_access(REQ_ANALYZE, 1, 0, 0, 100, 1));
        seq.push_back(make_access(REQ_ANALYZE, 0, 0, 0, 0, 1));
        seq.push_back(make_access(REQ_ANALYZE, 1, 0, 0, 0, 1));
        // unreserved entry at the top corner, then reserve it
        seq.push_back(make_access(REQ_ANALYZE, 1, 3, 1023, 32'hFFFF_FFFF, 0));
        seq.push_back(make_access(REQ_RESERVE, 1, 3, 1023, 32'hFFFF_FFFF, 0));
        seq.push_back(make_access(REQ_RESERVE, 0, 3, 1023, 1, 0));
        seq.push_back(make_access(REQ_ANALYZE, 1, 3, 1023, 32'hFFFF_FFFF, 1));
        seq.push_back(make_access(REQ_ANALYZE, 0, 3, 1023, 32'hFFFF_FFFF, 1));
        // flags built up then dropped by a reserve marked last
        seq.push_back(make_access(REQ_ANALYZE, 0, 0, 0, 150, 0));
        seq.push_back(make_access(REQ_ANALYZE, 1, 0, 0, 150, 0));
        seq.push_back(make_access(REQ_RESERVE, 0, 1, 5, 7, 1));
        seq.push_back(make_access(REQ_ANALYZE, 0, 2, 682, 3, 1));
        seq.push_back(make_access(REQ_RESERVE, 1, 2, 341, 32'h5555_5555, 1));
        seq.push_back(make_access(REQ_ANALYZE, 1, 2, 341, 32'hAAAA_AAAA, 1));
        seq.push_back(make_access(REQ_ANALYZE, 0, 2, 341, 32'h5555_5555, 1));
        foreach (seq[i]) send_access(seq[i]);
        wait_reports_drained();
    endtask

    // receiver stops while the sender keeps offering beats back to back
    task automatic test_backpressure();
        bit saved_idle;
        saved_idle      = tx_idle_en;
        tx_idle_en      = 0;
        holdoff_request = 400;
        repeat (80) begin
            send_access(make_access($urandom_range(1), $urandom_range(1), $urandom_range(3),
                                    $urandom_range(15), $urandom_range(300, 1), 1));
        end
        tx_idle_en = saved_idle;
        wait_reports_drained();
    endtask

    // batches of transactions reserve their sets, then analyze the same sets
    task automatic test_random_batches(input int target);
        req_t        batch [$];
        req_t        a;
        int          hot_slot [12];
        int          n_txn;
        int          n_acc;
        int          slot;
        int          next_drain;
        logic [31:0] base;
        logic [31:0] tid;
        next_drain = items_sent + 400;
        while (items_sent < target) begin
            // one long stretch with no idling on either side
            tx_idle_en = (items_sent > 300);
            rx_idle_en = (items_sent > 300);
            foreach (hot_slot[i]) hot_slot[i] = $urandom_range(SLOTS - 1);
            base  = $urandom_range(32'hFFFF_F000, 1);
            n_txn = $urandom_range(5, 2);
            batch.delete();
            for (int t = 0; t < n_txn; t++) begin
                if ($urandom_range(9) == 0) tid = $urandom;
                else tid = base + $urandom_range(255);
                if (tid == 0) tid = 1;
                n_acc = $urandom_range(6, 1);
                for (int j = 0; j < n_acc; j++) begin
                    slot = ($urandom_range(99) < 70) ? hot_slot[$urandom_range(11)]
                                                     : $urandom_range(SLOTS - 1);
                    a = make_access(REQ_RESERVE, $urandom_range(1), slot >> KEY_IDX_W,
                                    slot % (1 << KEY_IDX_W), tid, j == n_acc - 1);
                    batch.push_back(a);
                end
            end
            for (int pass = 0; pass < 2; pass++) begin
                foreach (batch[i]) begin
                    if ($urandom_range(99) < 12) send_access(noise_access());
                    a = batch[i];
                    a.req_type = (pass == 0) ? REQ_RESERVE : REQ_ANALYZE;
                    // occasionally break the set boundary
                    if ($urandom_range(99) < 4) a.last_access = ~a.last_access;
                    send_access(a);
                end
            end
            if (items_sent >= next_drain) begin
                wait_reports_drained();
                next_drain = items_sent + 400;
            end
        end
        s_tvalid = 1'b0;
    endtask

    // receiver: random stalls, plus a long hold-off counted here on request
    initial begin : receiver
        int hold_left;
        m_tready  = 1'b0;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (holdoff_request > 0) begin
                hold_left       = holdoff_request;
                holdoff_request = 0;
            end
            if (hold_left > 0) begin
                m_tready = 1'b0;
                hold_left--;
            end else if (rx_idle_en) begin
                m_tready = ($urandom_range(99) >= 27);
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : check_results
        dep_report_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_reports.size() == 0) begin
                report_mismatch("unexpected result beat, pending count", 0, 1);
            end else begin
                want = pending_reports.pop_front();
                if (m_tuser[0] !== want.done_kind)
                    report_mismatch("done_kind", want.done_kind, m_tuser[0]);
                if (m_tdata[FLAG_WAW] !== want.flags[FLAG_WAW])
                    report_mismatch("waw_found", want.flags[FLAG_WAW], m_tdata[FLAG_WAW]);
                if (m_tdata[FLAG_WAR] !== want.flags[FLAG_WAR])
                    report_mismatch("war_found", want.flags[FLAG_WAR], m_tdata[FLAG_WAR]);
                if (m_tdata[FLAG_RAW] !== want.flags[FLAG_RAW])
                    report_mismatch("raw_found", want.flags[FLAG_RAW], m_tdata[FLAG_RAW]);
            end
        end
    end

    initial begin
        aresetn         = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        s_tuser         = '0;
        s_tlast         = 1'b0;
        error_count     = 0;
        items_sent      = 0;
        holdoff_request = 0;
        tx_idle_en      = 1;
        rx_idle_en      = 1;
        running_deps    = '0;
        for (int i = 0; i < SLOTS; i++) begin
            read_marks[i]  = '0;
            write_marks[i] = '0;
        end
        repeat (7) @(negedge aclk);
        aresetn = 1'b1;

        // the clearing pass after reset shows up as s_tready held low
        test_directed();
        test_backpressure();
        test_random_batches(1950);
        wait_reports_drained();

        repeat (10) @(posedge aclk);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
